// ===== hdl/ffp_pkg.sv =====
// Shared types and constants for the format field parser.
// Used by every module of the parser; depends on nothing else.
package ffp_pkg;

    // Default widths of the position counters and the argument index
    localparam int POS_BITS_DEF   = 16;
    localparam int INDEX_BITS_DEF = 16;

    // Fixed widths of the stream fields
    localparam int CHAR_W  = 21;
    localparam int ARG_W   = 16;
    localparam int EPOS_W  = 16;
    localparam int KIND_W  = 3;
    localparam int ERR_W   = 2;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 56;

    // Characters with a meaning of their own
    localparam logic [CHAR_W-1:0] CH_OPEN  = CHAR_W'(8'h7B);
    localparam logic [CHAR_W-1:0] CH_CLOSE = CHAR_W'(8'h7D);
    localparam logic [CHAR_W-1:0] CH_COLON = CHAR_W'(8'h3A);
    localparam logic [CHAR_W-1:0] CH_ZERO  = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0] CH_NINE  = CHAR_W'(8'h39);

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_LITERAL     = 3'd0,
        KIND_FIELD_DONE  = 3'd1,
        KIND_SPEC_CHAR   = 3'd2,
        KIND_STRING_DONE = 3'd3,
        KIND_ERROR       = 3'd4
    } kind_t;

    // Error codes
    typedef enum logic [ERR_W-1:0] {
        ERR_NONE          = 2'd0,
        ERR_UNMATCHED     = 2'd1,
        ERR_SINGLE_CLOSE  = 2'd2,
        ERR_SPEC_EXPECTED = 2'd3
    } err_t;

    // One input character transfer
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              end_mark;
    } item_t;

    // One result transfer
    typedef struct packed {
        kind_t             kind;
        logic [CHAR_W-1:0] char_value;
        logic [ARG_W-1:0]  arg_number;
        logic              has_spec;
        err_t              error_code;
        logic [EPOS_W-1:0] error_position;
    } result_t;

endpackage

// ===== hdl/ffp_in_stage.sv =====
// Input register of the format field parser.
// Holds one character transfer until the parse core consumes it; uses ffp_pkg.
module ffp_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ffp_pkg::item_t s_item,
    output logic           item_valid,
    output ffp_pkg::item_t item,
    input  logic           item_take
);

    logic           valid_reg;
    logic           valid_next;
    ffp_pkg::item_t item_reg;

    // Accept when empty or when the held item leaves this cycle
    assign s_ready    = !valid_reg || item_take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !item_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload on every transfer
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hdl/ffp_parse_core.sv =====
// Parse state and next-state logic of the format field parser.
// One character is consumed per cycle when the output stage has room; uses ffp_pkg.
module ffp_parse_core #(
    parameter int POS_BITS   = ffp_pkg::POS_BITS_DEF,
    parameter int INDEX_BITS = ffp_pkg::INDEX_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             item_valid,
    input  ffp_pkg::item_t   item,
    input  logic             out_ready,
    output logic             item_take,
    output logic             res_valid,
    output ffp_pkg::result_t res
);

    typedef enum logic [6:0] {
        PH_TEXT       = 7'b0000001,
        PH_OPEN       = 7'b0000010,
        PH_CLOSE      = 7'b0000100,
        PH_DIGITS     = 7'b0001000,
        PH_SPEC_START = 7'b0010000,
        PH_SPEC       = 7'b0100000,
        PH_DROP       = 7'b1000000
    } phase_t;

    localparam logic [POS_BITS-1:0]   POS_MAX  = {POS_BITS{1'b1}};
    localparam logic [INDEX_BITS-1:0] IDX_MAX  = {INDEX_BITS{1'b1}};
    localparam logic [INDEX_BITS:0]   IDX_NONE = {(INDEX_BITS+1){1'b1}};

    phase_t                phase_reg, phase_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic [POS_BITS-1:0]   fstart_reg, fstart_next;
    logic [INDEX_BITS-1:0] acc_reg, acc_next;
    logic [INDEX_BITS:0]   last_reg, last_next;
    logic                  given_reg, given_next;

    logic [POS_BITS-1:0]   pos_inc;
    logic [POS_BITS-1:0]   pos_dec;
    logic                  is_digit;
    logic [3:0]            digit;
    logic [INDEX_BITS+3:0] mac;
    logic [INDEX_BITS-1:0] mac_sat;
    logic [INDEX_BITS-1:0] field_idx;
    logic [ffp_pkg::CHAR_W-1:0] ch;

    assign item_take = item_valid && out_ready;
    assign ch        = item.char_code;

    // Saturating position of the current character
    assign pos_inc = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
    assign pos_dec = pos_inc - 1'b1;

    // Decimal index accumulate: acc * 8 + acc * 2 + digit, saturating
    assign is_digit = (ch >= ffp_pkg::CH_ZERO) && (ch <= ffp_pkg::CH_NINE);
    assign digit    = ch[3:0];
    assign mac      = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                    + {{INDEX_BITS{1'b0}}, digit};
    assign mac_sat  = (mac[INDEX_BITS+3:INDEX_BITS] != 4'd0) ? IDX_MAX
                                                            : mac[INDEX_BITS-1:0];

    // Index of a completing field: given, or next after the last one used
    always_comb begin
        if (given_reg) begin
            field_idx = acc_reg;
        end else if (last_reg == IDX_NONE) begin
            field_idx = '0;
        end else if (last_reg[INDEX_BITS-1:0] == IDX_MAX) begin
            field_idx = IDX_MAX;
        end else begin
            field_idx = last_reg[INDEX_BITS-1:0] + 1'b1;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        fstart_next = fstart_reg;
        acc_next    = acc_reg;
        last_next   = last_reg;
        given_next  = given_reg;
        res_valid   = 1'b0;
        res.kind           = ffp_pkg::KIND_LITERAL;
        res.char_value     = '0;
        res.arg_number     = '0;
        res.has_spec       = 1'b0;
        res.error_code     = ffp_pkg::ERR_NONE;
        res.error_position = '0;

        if (item_take) begin
            if (item.end_mark) begin
                // Close the string and report what is left open
                case (phase_reg)
                    PH_TEXT: begin
                        res_valid = 1'b1;
                        res.kind  = ffp_pkg::KIND_STRING_DONE;
                    end
                    PH_OPEN, PH_DIGITS, PH_SPEC: begin
                        res_valid          = 1'b1;
                        res.kind           = ffp_pkg::KIND_ERROR;
                        res.error_code     = ffp_pkg::ERR_UNMATCHED;
                        res.error_position = ffp_pkg::EPOS_W'({{ffp_pkg::EPOS_W{1'b0}},
                                                               fstart_reg});
                    end
                    PH_CLOSE: begin
                        res_valid          = 1'b1;
                        res.kind           = ffp_pkg::KIND_ERROR;
                        res.error_code     = ffp_pkg::ERR_SINGLE_CLOSE;
                        res.error_position = ffp_pkg::EPOS_W'({{ffp_pkg::EPOS_W{1'b0}},
                                                               pos_reg});
                    end
                    PH_SPEC_START: begin
                        res_valid          = 1'b1;
                        res.kind           = ffp_pkg::KIND_ERROR;
                        res.error_code     = ffp_pkg::ERR_SPEC_EXPECTED;
                        res.error_position = ffp_pkg::EPOS_W'({{ffp_pkg::EPOS_W{1'b0}},
                                                               pos_inc});
                    end
                    default: ;
                endcase
                // Restart for the next string
                phase_next  = PH_TEXT;
                pos_next    = '0;
                fstart_next = '0;
                acc_next    = '0;
                last_next   = IDX_NONE;
                given_next  = 1'b0;
            end else if (phase_reg != PH_DROP) begin
                pos_next = pos_inc;
                case (phase_reg)
                    PH_TEXT: begin
                        if (ch == ffp_pkg::CH_OPEN) begin
                            fstart_next = pos_inc;
                            phase_next  = PH_OPEN;
                        end else if (ch == ffp_pkg::CH_CLOSE) begin
                            phase_next = PH_CLOSE;
                        end else begin
                            res_valid      = 1'b1;
                            res.kind       = ffp_pkg::KIND_LITERAL;
                            res.char_value = ch;
                        end
                    end
                    PH_OPEN, PH_DIGITS: begin
                        if (phase_reg == PH_OPEN && ch == ffp_pkg::CH_OPEN) begin
                            // Doubled open brace
                            phase_next     = PH_TEXT;
                            res_valid      = 1'b1;
                            res.kind       = ffp_pkg::KIND_LITERAL;
                            res.char_value = ffp_pkg::CH_OPEN;
                        end else if (is_digit) begin
                            acc_next   = (phase_reg == PH_OPEN) ? INDEX_BITS'(digit)
                                                                : mac_sat;
                            given_next = 1'b1;
                            phase_next = PH_DIGITS;
                        end else if (ch == ffp_pkg::CH_COLON) begin
                            phase_next = PH_SPEC_START;
                        end else if (ch == ffp_pkg::CH_CLOSE) begin
                            res_valid      = 1'b1;
                            res.kind       = ffp_pkg::KIND_FIELD_DONE;
                            res.arg_number = ffp_pkg::ARG_W'({{ffp_pkg::ARG_W{1'b0}},
                                                              field_idx});
                            last_next      = {1'b0, field_idx};
                            given_next     = 1'b0;
                            acc_next       = '0;
                            phase_next     = PH_TEXT;
                        end else begin
                            res_valid          = 1'b1;
                            res.kind           = ffp_pkg::KIND_ERROR;
                            res.error_code     = ffp_pkg::ERR_UNMATCHED;
                            res.error_position = ffp_pkg::EPOS_W'({{ffp_pkg::EPOS_W{1'b0}},
                                                                   fstart_reg});
                            phase_next         = PH_DROP;
                        end
                    end
                    PH_CLOSE: begin
                        if (ch == ffp_pkg::CH_CLOSE) begin
                            // Doubled close brace
                            phase_next     = PH_TEXT;
                            res_valid      = 1'b1;
                            res.kind       = ffp_pkg::KIND_LITERAL;
                            res.char_value = ffp_pkg::CH_CLOSE;
                        end else begin
                            res_valid          = 1'b1;
                            res.kind           = ffp_pkg::KIND_ERROR;
                            res.error_code     = ffp_pkg::ERR_SINGLE_CLOSE;
                            res.error_position = ffp_pkg::EPOS_W'({{ffp_pkg::EPOS_W{1'b0}},
                                                                   pos_dec});
                            phase_next         = PH_DROP;
                        end
                    end
                    PH_SPEC_START, PH_SPEC: begin
                        if (ch == ffp_pkg::CH_CLOSE) begin
                            res_valid      = 1'b1;
                            res.kind       = ffp_pkg::KIND_FIELD_DONE;
                            res.arg_number = ffp_pkg::ARG_W'({{ffp_pkg::ARG_W{1'b0}},
                                                              field_idx});
                            res.has_spec   = 1'b1;
                            last_next      = {1'b0, field_idx};
                            given_next     = 1'b0;
                            acc_next       = '0;
                            phase_next     = PH_TEXT;
                        end else begin
                            res_valid      = 1'b1;
                            res.kind       = ffp_pkg::KIND_SPEC_CHAR;
                            res.char_value = ch;
                            phase_next     = PH_SPEC;
                        end
                    end
                    default: begin
                        phase_next = PH_DROP;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_TEXT;
            pos_reg    <= '0;
            fstart_reg <= '0;
            acc_reg    <= '0;
            last_reg   <= IDX_NONE;
            given_reg  <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            fstart_reg <= fstart_next;
            acc_reg    <= acc_next;
            last_reg   <= last_next;
            given_reg  <= given_next;
        end
    end

endmodule

// ===== hdl/ffp_out_stage.sv =====
// Result register of the format field parser.
// Holds one result transfer until the downstream side takes it; uses ffp_pkg.
module ffp_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             res_valid,
    input  ffp_pkg::result_t res,
    output logic             out_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output ffp_pkg::result_t m_res
);

    logic             valid_reg;
    logic             valid_next;
    ffp_pkg::result_t res_reg;

    // Room when empty or when the held result leaves this cycle
    assign out_ready  = !valid_reg || m_ready;
    assign valid_next = (out_ready && res_valid) || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load a new result when one is produced
    always_ff @(posedge aclk) begin
        if (out_ready && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

// ===== hdl/format_field_parser.sv =====
// Top level of the format field parser: input register, parse core, result register.
// Depends on ffp_pkg, ffp_in_stage, ffp_parse_core and ffp_out_stage.
//
//  Channel  Direction  Payload                                       Marker
//  s_axis   in         tdata: char_code                              tlast: end_mark
//  m_axis   out        tdata: char_value .. error_position           tuser: kind
//
// One character per cycle is sustained while m_axis takes results. A result passes
// the input register, a single pass of state-update logic and then the result
// register; characters that give no result are still taken at that rate.
// Reset (aresetn low, synchronous) empties both registers and sets the text phase.
// A stall on m_axis fills the result register, then the input register, and then
// holds s_axis_tready low.
module format_field_parser #(
    parameter int POS_BITS   = ffp_pkg::POS_BITS_DEF,
    parameter int INDEX_BITS = ffp_pkg::INDEX_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: [20:0] char_code, [23:21] zero
    input  logic [ffp_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // tlast: end_mark
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata: [20:0] char_value, [36:21] arg_number, [37] has_spec,
    //        [39:38] error_code, [55:40] error_position
    output logic [ffp_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // tuser: [2:0] kind
    output logic [ffp_pkg::KIND_W-1:0]    m_axis_tuser
);

    ffp_pkg::item_t   s_item;
    ffp_pkg::item_t   item;
    logic             item_valid;
    logic             item_take;
    logic             out_ready;
    logic             res_valid;
    ffp_pkg::result_t res;
    ffp_pkg::result_t m_res;

    assign s_item.char_code = s_axis_tdata[ffp_pkg::CHAR_W-1:0];
    assign s_item.end_mark  = s_axis_tlast;

    ffp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    ffp_parse_core #(
        .POS_BITS   (POS_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .out_ready  (out_ready),
        .item_take  (item_take),
        .res_valid  (res_valid),
        .res        (res)
    );

    ffp_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_res     (m_res)
    );

    // Pack the result fields, char_value in the lowest bits
    assign m_axis_tdata = {m_res.error_position, m_res.error_code, m_res.has_spec,
                           m_res.arg_number, m_res.char_value};
    assign m_axis_tuser = m_res.kind;

endmodule
